[design/oppd_pkg.sv]
`timescale 1ns / 1ps
package oppd_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_SAMPLES = 4096;
	localparam int INDEX_BITS  = 12;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [INDEX_BITS-1:0]  index_t;

	// index saturates at the smaller of MAX_SAMPLES-1 and the field maximum
	localparam int INDEX_LIMIT_INT = (MAX_SAMPLES - 1 < (1 << INDEX_BITS) - 1) ?
		MAX_SAMPLES - 1 : (1 << INDEX_BITS) - 1;
	localparam index_t INDEX_LIMIT = index_t'(INDEX_LIMIT_INT);

	// 50 mmHg in converter counts
	localparam sample_t STOP_LEVEL_RESET = sample_t'(1411853);

	typedef struct packed {
		index_t  peak_index;
		sample_t peak_rise;
		logic    peak_valid;
		logic    done_res;
	} result_t;

endpackage

[design/oppd_if.sv]
`timescale 1ns / 1ps
interface oppd_sample_if import oppd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t pressure;
	logic    first;

	modport source (output valid, output pressure, output first, input ready);
	modport sink (input valid, input pressure, input first, output ready);
endinterface

interface oppd_peak_if import oppd_pkg::*; ();
	logic    valid;
	logic    ready;
	index_t  peak_index;
	sample_t peak_rise;
	logic    peak_valid;
	logic    done_res;

	modport source (output valid, output peak_index, output peak_rise, output peak_valid,
		output done_res, input ready);
	modport sink (input valid, input peak_index, input peak_rise, input peak_valid,
		input done_res, output ready);
endinterface

interface oppd_cfg_if import oppd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t stop_level;

	modport source (output valid, output stop_level, input ready);
	modport sink (input valid, input stop_level, output ready);
endinterface

[design/oscillometric_pulse_peak_detector.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Handshake
// samples   in   pressure[23:0], first                          valid/ready
// peaks     out  peak_index[11:0], peak_rise[23:0], peak_valid,  valid/ready
//                done_res
// cfg       in   stop_level[23:0]                               valid/ready, always ready
//
// One sample per cycle sustained unless the result register stalls: input register,
// then the rise subtract/compare and run tracking feed the result register.
// Reset clears the pipeline and leaves the detector idle until a first sample;
// stop_level returns to 1411853.
// A stalled result register holds the input register; samples keep flowing while
// the result register is free or being taken in the same cycle.
module oscillometric_pulse_peak_detector import oppd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	oppd_sample_if.sink  samples,
	oppd_peak_if.source  peaks,
	oppd_cfg_if.sink     cfg
);

	logic    valid_s1;
	sample_t pressure_s1;
	logic    first_s1;

	sample_t stop_level_q;
	sample_t prev_q;
	index_t  index_q;
	logic    run_open_q;
	sample_t run_max_q;
	index_t  run_max_index_q;
	logic    fin_q;

	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	sample_t prev_d;
	index_t  index_d;
	index_t  index_inc;
	logic    run_open_d;
	sample_t run_max_d;
	index_t  run_max_index_d;
	logic    fin_d;
	logic    emit;
	result_t res;
	logic    at_stop;
	sample_t rise;

	assign advance       = valid_s1 && (!out_valid_q || peaks.ready);
	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			pressure_s1 <= samples.pressure;
			first_s1    <= samples.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_level_q <= STOP_LEVEL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			stop_level_q <= cfg.stop_level;
		end
	end

	assign at_stop   = pressure_s1 <= stop_level_q;
	assign rise      = pressure_s1 - prev_q;
	assign index_inc = (index_q < INDEX_LIMIT) ? index_q + index_t'(1) : index_q;

	always_comb begin
		prev_d          = prev_q;
		index_d         = index_q;
		run_open_d      = run_open_q;
		run_max_d       = run_max_q;
		run_max_index_d = run_max_index_q;
		fin_d           = fin_q;
		emit            = 1'b0;
		res             = '0;
		if (first_s1) begin
			prev_d          = pressure_s1;
			index_d         = '0;
			run_open_d      = 1'b0;
			run_max_d       = '0;
			run_max_index_d = '0;
			fin_d           = at_stop;
			if (at_stop) begin
				emit         = 1'b1;
				res.done_res = 1'b1;
			end
		end else if (!fin_q) begin
			index_d = index_inc;
			prev_d  = pressure_s1;
			if (at_stop) begin
				fin_d        = 1'b1;
				run_open_d   = 1'b0;
				emit         = 1'b1;
				res.done_res = 1'b1;
				if (run_open_q) begin
					res.peak_index = run_max_index_q;
					res.peak_rise  = run_max_q;
					res.peak_valid = 1'b1;
				end
			end else if (pressure_s1 > prev_q) begin
				// rising edge: open a run or raise its maximum; earlier index wins ties
				if (!run_open_q || rise > run_max_q) begin
					run_max_d       = rise;
					run_max_index_d = index_inc;
				end
				run_open_d = 1'b1;
			end else if (run_open_q) begin
				run_open_d     = 1'b0;
				emit           = 1'b1;
				res.peak_index = run_max_index_q;
				res.peak_rise  = run_max_q;
				res.peak_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q          <= '0;
			index_q         <= '0;
			run_open_q      <= 1'b0;
			run_max_q       <= '0;
			run_max_index_q <= '0;
			fin_q           <= 1'b1;
		end else if (advance) begin
			prev_q          <= prev_d;
			index_q         <= index_d;
			run_open_q      <= run_open_d;
			run_max_q       <= run_max_d;
			run_max_index_q <= run_max_index_d;
			fin_q           <= fin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || peaks.ready) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign peaks.valid      = out_valid_q;
	assign peaks.peak_index = out_q.peak_index;
	assign peaks.peak_rise  = out_q.peak_rise;
	assign peaks.peak_valid = out_q.peak_valid;
	assign peaks.done_res   = out_q.done_res;

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.peak_valid |-> out_q.peak_index == '0 && out_q.peak_rise == '0)
		else $error("result without peak carries nonzero fields");

	a_open_run_positive: assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> run_max_q != '0)
		else $error("open run with zero maximum rise");

	a_finished_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !run_open_q)
		else $error("run left open after sweep end");

	a_done_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res.done_res |=> fin_q)
		else $error("done result did not end the sweep");

endmodule

[test/oppd_checker.sv]
`timescale 1ns / 1ps
module oppd_checker import oppd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	oppd_sample_if samples,
	oppd_peak_if   peaks,
	oppd_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding
);

	sample_t stop_level;
	sample_t last_pressure;
	sample_t run_peak_rise;
	index_t  sample_no;
	index_t  run_peak_index;
	logic    in_run;
	logic    sweep_over;
	result_t peaks_due[$];

	function automatic result_t make_peak(index_t idx, sample_t rise, logic valid, logic done);
		result_t r;
		r.peak_index = idx;
		r.peak_rise  = rise;
		r.peak_valid = valid;
		r.done_res   = done;
		return r;
	endfunction

	// advance the detector model by one accepted sample request
	task automatic follow_sample(input sample_t p, input logic first);
		sample_t rise;
		if (first) begin
			last_pressure  = p;
			sample_no      = '0;
			in_run         = 1'b0;
			run_peak_rise  = '0;
			run_peak_index = '0;
			sweep_over     = 1'b0;
			if (p <= stop_level) begin
				sweep_over = 1'b1;
				peaks_due.push_back(make_peak('0, '0, 1'b0, 1'b1));
			end
			return;
		end
		if (sweep_over)
			return;
		if (sample_no < INDEX_LIMIT)
			sample_no++;
		if (p <= stop_level) begin
			last_pressure = p;
			sweep_over    = 1'b1;
			if (in_run)
				peaks_due.push_back(make_peak(run_peak_index, run_peak_rise, 1'b1, 1'b1));
			else
				peaks_due.push_back(make_peak('0, '0, 1'b0, 1'b1));
			in_run = 1'b0;
			return;
		end
		if (p > last_pressure) begin
			rise          = p - last_pressure;
			last_pressure = p;
			// earliest index keeps a tie
			if (!in_run || rise > run_peak_rise) begin
				run_peak_rise  = rise;
				run_peak_index = sample_no;
			end
			in_run = 1'b1;
			return;
		end
		last_pressure = p;
		if (in_run) begin
			in_run = 1'b0;
			peaks_due.push_back(make_peak(run_peak_index, run_peak_rise, 1'b1, 1'b0));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			stop_level     = STOP_LEVEL_RESET;
			last_pressure  = '0;
			sample_no      = '0;
			in_run         = 1'b0;
			run_peak_rise  = '0;
			run_peak_index = '0;
			sweep_over     = 1'b1;
			peaks_due.delete();
			mismatches     = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				stop_level = cfg.stop_level;
			if (samples.valid && samples.ready)
				follow_sample(samples.pressure, samples.first);
			if (peaks.valid && peaks.ready) begin
				if (peaks_due.size() == 0) begin
					$display("%0t: unexpected peak result: expected none, got idx=%0d rise=%0d valid=%b done=%b",
						$time, peaks.peak_index, peaks.peak_rise, peaks.peak_valid,
						peaks.done_res);
					mismatches++;
				end else begin
					want = peaks_due.pop_front();
					if (peaks.peak_index !== want.peak_index) begin
						$display("%0t: peak_index expected %0d got %0d",
							$time, want.peak_index, peaks.peak_index);
						mismatches++;
					end
					if (peaks.peak_rise !== want.peak_rise) begin
						$display("%0t: peak_rise expected %0d got %0d",
							$time, want.peak_rise, peaks.peak_rise);
						mismatches++;
					end
					if (peaks.peak_valid !== want.peak_valid) begin
						$display("%0t: peak_valid expected %b got %b",
							$time, want.peak_valid, peaks.peak_valid);
						mismatches++;
					end
					if (peaks.done_res !== want.done_res) begin
						$display("%0t: done_res expected %b got %b",
							$time, want.done_res, peaks.done_res);
						mismatches++;
					end
				end
			end
		end
		outstanding = peaks_due.size();
	end

endmodule

[test/oscillometric_pulse_peak_detector_tb.sv]
`timescale 1ns / 1ps
module oscillometric_pulse_peak_detector_tb;
	import oppd_pkg::*;

	typedef enum int {FREE_RUN, COIN_FLIP, SPARSE, BLINK} stall_mode_e;

	logic    clk;
	logic    arst_n;
	logic    hold_req;
	logic    no_idle;
	int      burst_left;
	int      phase_items;
	int      chk_mismatches;
	int      chk_outstanding;
	sample_t stop_now;

	oppd_sample_if sample_ch ();
	oppd_peak_if   peak_ch ();
	oppd_cfg_if    cfg_ch ();

	oscillometric_pulse_peak_detector uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.peaks   (peak_ch),
		.cfg     (cfg_ch)
	);

	oppd_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (sample_ch),
		.peaks       (peak_ch),
		.cfg         (cfg_ch),
		.mismatches  (chk_mismatches),
		.outstanding (chk_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: stall pattern of its own, plus one long hold-off on request
	initial begin
		stall_mode_e mode;
		int left;
		int tick;
		logic held;
		peak_ch.ready = 1'b0;
		mode = FREE_RUN;
		left = 0;
		tick = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				peak_ch.ready = 1'b0;
				repeat (150) @(negedge clk);
			end
			if (left == 0) begin
				mode = stall_mode_e'($urandom_range(BLINK, FREE_RUN));
				left = $urandom_range(120, 20);
			end
			left--;
			tick++;
			case (mode)
				FREE_RUN:  peak_ch.ready = 1'b1;
				COIN_FLIP: peak_ch.ready = 1'($urandom_range(1, 0));
				SPARSE:    peak_ch.ready = ($urandom_range(3, 0) == 0);
				default:   peak_ch.ready = (tick % 6) < 3;
			endcase
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer(input sample_t p, input logic first);
		if (burst_left == 0) begin
			if (!no_idle) begin
				sample_ch.valid = 1'b0;
				repeat ($urandom_range(8, 1)) @(negedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		sample_ch.pressure = p;
		sample_ch.first    = first;
		sample_ch.valid    = 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// quiet the sample side and let every pending peak drain
	task automatic settle();
		sample_ch.valid = 1'b0;
		wait (chk_outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_stop(input sample_t v);
		settle();
		cfg_ch.stop_level = v;
		cfg_ch.valid      = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		stop_now     = v;
	endtask

	// one deflation sweep: random walk kept above the stop level, then usually an end sample
	task automatic run_sweep(input int len, input int unsigned step_max);
		int unsigned level;
		int unsigned last_rise;
		int unsigned r;
		int kind;
		if (stop_now == '1) begin
			// every first sample ends at once; trailing samples are ignored
			offer(sample_t'($urandom), 1'b1);
			phase_items++;
			repeat ($urandom_range(2, 0)) offer(sample_t'($urandom), 1'b0);
			return;
		end
		level = $urandom_range(24'hFFFFFF, stop_now + 1);
		last_rise = 1;
		offer(sample_t'(level), 1'b1);
		phase_items++;
		for (int i = 0; i < len; i++) begin
			kind = $urandom_range(9, 0);
			r = $urandom_range(step_max, 1);
			if (kind == 8)
				r = last_rise;
			if (kind <= 3 || kind == 8) begin
				if (r > 24'hFFFFFF - level)
					r = 24'hFFFFFF - level;
				level += r;
				if (r != 0)
					last_rise = r;
			end else if (kind <= 6) begin
				if (level - stop_now <= r)
					level = stop_now + 1;
				else
					level -= r;
			end else if (kind == 9) begin
				level = $urandom_range(24'hFFFFFF, stop_now + 1);
			end
			offer(sample_t'(level), 1'b0);
			phase_items++;
		end
		// now and then leave the sweep open so the next first sample cuts it off
		if ($urandom_range(7, 0) != 0) begin
			offer(sample_t'($urandom_range(stop_now, 0)), 1'b0);
			phase_items++;
			if ($urandom_range(3, 0) == 0)
				repeat ($urandom_range(3, 1)) offer(sample_t'($urandom), 1'b0);
		end
	endtask

	function automatic int unsigned pick_step();
		case ($urandom_range(3, 0))
			0:       return 4;
			1:       return 300;
			2:       return 65536;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	initial begin
		sample_t stops[6];
		arst_n             = 1'b0;
		hold_req           = 1'b0;
		no_idle            = 1'b0;
		burst_left         = 0;
		phase_items        = 0;
		stop_now           = STOP_LEVEL_RESET;
		sample_ch.valid    = 1'b0;
		sample_ch.pressure = '0;
		sample_ch.first    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.stop_level  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, at the reset stop level
		offer(24'd12345, 1'b0);          // idle after reset: ignored
		offer(24'd0, 1'b1);              // first sample already below stop
		offer(24'd2000000, 1'b1);
		offer(24'd2000100, 1'b0);
		offer(24'd2000300, 1'b0);
		offer(24'd2000500, 1'b0);        // equal rise: earlier index stays
		offer(24'd2000500, 1'b0);        // flat closes the run
		offer(24'd1900000, 1'b0);
		offer(24'd1900050, 1'b0);
		offer(24'd1800000, 1'b0);        // fall closes the run
		offer(24'd1411854, 1'b0);
		offer(STOP_LEVEL_RESET, 1'b0);   // end with no run open
		offer(24'd5000000, 1'b0);        // ignored after sweep end
		offer(STOP_LEVEL_RESET, 1'b1);
		offer(24'd3000000, 1'b1);
		offer(24'hFFFFFF, 1'b0);
		offer(24'd100, 1'b0);            // end with a run open
		offer(24'd2000000, 1'b1);
		offer(24'd2000010, 1'b0);
		offer(24'd2500000, 1'b1);        // restart mid-run
		offer(24'd2400000, 1'b0);
		offer(24'd2400001, 1'b0);
		offer(24'd1, 1'b0);

		// back-to-back small pulses while the result side holds off
		set_stop(sample_t'($urandom_range(24'h200000, 24'h1000)));
		no_idle     = 1'b1;
		hold_req    = 1'b1;
		phase_items = 0;
		while (phase_items < 100)
			run_sweep($urandom_range(12, 6), 4);

		stops = '{24'h000000, sample_t'($urandom_range(24'hFFFFFE, 1)), 24'hFFFFFF,
			24'h800000, 24'h7FFFFF, STOP_LEVEL_RESET};
		for (int ph = 0; ph < 6; ph++) begin
			set_stop(stops[ph]);
			no_idle     = ph[0];
			phase_items = 0;
			while (phase_items < ((stops[ph] == '1) ? 40 : 90))
				run_sweep($urandom_range(40, 3), pick_step());
		end

		settle();
		repeat (10) @(posedge clk);
		if (chk_mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[oscillometric_pulse_peak_detector.f]
design/oppd_pkg.sv
design/oppd_if.sv
design/oscillometric_pulse_peak_detector.sv
test/oppd_checker.sv
test/oscillometric_pulse_peak_detector_tb.sv
